// ----- sv/deque_pkg.sv -----
// Shared types and codes for the double-ended queue.
// It has no dependencies. The controller, the datapath and the top level use it.
package deque_pkg;

  typedef enum logic [1:0] {
    MODE_PUSH_FRONT = 2'd0,
    MODE_PUSH_BACK  = 2'd1,
    MODE_POP_FRONT  = 2'd2,
    MODE_POP_BACK   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_e;

  typedef enum logic {
    STATE_IDLE = 1'b0,
    STATE_BUSY = 1'b1
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;  // take the input transaction and run the operation
    logic load;    // move the finished result into the output register
  } cmd_t;

endpackage

// ----- sv/deque_ctrl.sv -----
// Controller for the double-ended queue. It sequences acceptance and the result load.
// It depends on deque_pkg and drives commands to deque_dp.
module deque_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                out_stall_i,
  input  logic                out_full_i,
  output deque_pkg::cmd_t     cmd_o
);

  deque_pkg::state_e state_q, state_d;
  logic              load_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= deque_pkg::STATE_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    load_ok      = !out_full_i || !out_stall_i;
    state_d      = state_q;
    in_stall_o   = 1'b0;
    cmd_o.accept = 1'b0;
    cmd_o.load   = 1'b0;
    unique case (state_q)
      deque_pkg::STATE_IDLE: begin
        cmd_o.accept = in_valid_i;
        if (in_valid_i) begin
          state_d = deque_pkg::STATE_BUSY;
        end
      end
      deque_pkg::STATE_BUSY: begin
        // Hold the pending result until the output register frees up.
        in_stall_o   = !load_ok;
        cmd_o.load   = load_ok;
        cmd_o.accept = in_valid_i && load_ok;
        if (load_ok && !in_valid_i) begin
          state_d = deque_pkg::STATE_IDLE;
        end
      end
      default: state_d = deque_pkg::STATE_IDLE;
    endcase
  end

  a_idle_no_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == deque_pkg::STATE_IDLE) |-> !in_stall_o)
    else $error("stall raised while idle");

  a_load_only_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |-> (state_q == deque_pkg::STATE_BUSY))
    else $error("result load without pending operation");

  a_accept_goes_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.accept |=> (state_q == deque_pkg::STATE_BUSY))
    else $error("accepted transaction lost by controller");

endmodule

// ----- sv/deque_dp.sv -----
// Datapath for the double-ended queue: the ring store, the pointers and the output register.
// It depends on deque_pkg and takes its commands from deque_ctrl.
module deque_dp #(
  parameter int CAPACITY = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  deque_pkg::cmd_t                      cmd_i,
  input  logic [1:0]                           mode_i,
  input  logic signed [31:0]                   push_value_i,
  input  logic                                 out_stall_i,
  output logic                                 out_full_o,
  output logic                                 out_valid_o,
  output logic signed [31:0]                   popped_value_o,
  output logic [1:0]                           status_o,
  output logic [$clog2(CAPACITY+1)-1:0]        fill_count_o
);

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int SUM_W = CNT_W + 1;
  localparam logic [SUM_W-1:0] CAP_S    = SUM_W'(CAPACITY);
  localparam logic [CNT_W-1:0] CAP_C    = CNT_W'(CAPACITY);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

  logic [31:0]       mem_q [CAPACITY];
  logic [31:0]       rdata_q;
  logic [IDX_W-1:0]  head_q, head_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [1:0]        res_status_q, res_status_d;
  logic              res_pop_q, res_pop_d;
  logic [CNT_W-1:0]  res_count_q;
  logic              out_valid_q;
  logic [31:0]       out_value_q;
  logic [1:0]        out_status_q;
  logic [CNT_W-1:0]  out_count_q;

  logic              full, empty, is_push;
  logic [SUM_W-1:0]  sum_tail, sum_back;
  logic [IDX_W-1:0]  tail_idx, back_idx, head_inc, head_dec, addr;
  logic              wr_en, rd_en;

  always_comb begin
    full     = (count_q == CAP_C);
    empty    = (count_q == '0);
    is_push  = !mode_i[1];
    sum_tail = SUM_W'(head_q) + SUM_W'(count_q);
    sum_back = sum_tail - SUM_W'(1);
    tail_idx = (sum_tail >= CAP_S) ? IDX_W'(sum_tail - CAP_S) : IDX_W'(sum_tail);
    back_idx = (sum_back >= CAP_S) ? IDX_W'(sum_back - CAP_S) : IDX_W'(sum_back);
    head_inc = (head_q == LAST_IDX) ? '0 : head_q + IDX_W'(1);
    head_dec = (head_q == '0) ? LAST_IDX : head_q - IDX_W'(1);

    head_d       = head_q;
    count_d      = count_q;
    addr         = head_q;
    wr_en        = 1'b0;
    rd_en        = 1'b0;
    res_status_d = deque_pkg::STATUS_OK;
    res_pop_d    = 1'b0;

    if (is_push && full) begin
      res_status_d = deque_pkg::STATUS_FULL;
    end else if (!is_push && empty) begin
      res_status_d = deque_pkg::STATUS_EMPTY;
    end else begin
      unique case (deque_pkg::mode_e'(mode_i))
        deque_pkg::MODE_PUSH_FRONT: begin
          head_d  = head_dec;
          addr    = head_dec;
          wr_en   = 1'b1;
          count_d = count_q + CNT_W'(1);
        end
        deque_pkg::MODE_PUSH_BACK: begin
          addr    = tail_idx;
          wr_en   = 1'b1;
          count_d = count_q + CNT_W'(1);
        end
        deque_pkg::MODE_POP_FRONT: begin
          head_d    = head_inc;
          rd_en     = 1'b1;
          res_pop_d = 1'b1;
          count_d   = count_q - CNT_W'(1);
        end
        deque_pkg::MODE_POP_BACK: begin
          addr      = back_idx;
          rd_en     = 1'b1;
          res_pop_d = 1'b1;
          count_d   = count_q - CNT_W'(1);
        end
        default: ;
      endcase
    end
  end

  // Ring store: one port, registered read.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && wr_en) begin
      mem_q[addr] <= push_value_i;
    end
    if (cmd_i.accept && rd_en) begin
      rdata_q <= mem_q[addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
    end else if (cmd_i.accept) begin
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      res_status_q <= res_status_d;
      res_pop_q    <= res_pop_d;
      res_count_q  <= count_d;
    end
    if (cmd_i.load) begin
      out_value_q  <= res_pop_q ? rdata_q : '0;
      out_status_q <= res_status_q;
      out_count_q  <= res_count_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_full_o     = out_valid_q;
  assign out_valid_o    = out_valid_q;
  assign popped_value_o = out_value_q;
  assign status_o       = out_status_q;
  assign fill_count_o   = out_count_q;

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CAP_C)
    else $error("element count above capacity");

  a_full_push_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.accept && is_push && full) |=> (count_q == $past(count_q) &&
                                           head_q == $past(head_q)))
    else $error("refused push changed queue state");

  a_empty_pop_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.accept && !is_push && empty) |=> (count_q == $past(count_q) &&
                                             head_q == $past(head_q)))
    else $error("refused pop changed queue state");

  a_load_sets_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |=> out_valid_q)
    else $error("loaded result not presented");

endmodule

// ----- sv/double_ended_queue_top.sv -----
// Double-ended queue of signed 32-bit words kept in a ring store of CAPACITY entries.
// Each transaction pushes or pops at either end and returns one result: the popped word,
// a status (ok, pop on empty, push on full) and the fill count afterwards. The block
// sustains one transaction per cycle while the input is not stalled. The store read and
// the status of an accepted transaction land in a result register, and the result then
// moves into the output register once that register is free. While that output
// register is full and stalled, the input stalls too. Refused operations leave the
// queue unchanged.
// Depends on deque_pkg, deque_ctrl and deque_dp.
module double_ended_queue_top #(
  parameter int CAPACITY = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [1:0]                           mode_i,
  input  logic signed [31:0]                   push_value_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [31:0]                   popped_value_o,
  output logic [1:0]                           status_o,
  output logic [$clog2(CAPACITY+1)-1:0]        fill_count_o
);

  deque_pkg::cmd_t cmd;
  logic            out_full;

  deque_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_stall_i (out_stall_i),
    .out_full_i  (out_full),
    .cmd_o       (cmd)
  );

  deque_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .mode_i         (mode_i),
    .push_value_i   (push_value_i),
    .out_stall_i    (out_stall_i),
    .out_full_o     (out_full),
    .out_valid_o    (out_valid_o),
    .popped_value_o (popped_value_o),
    .status_o       (status_o),
    .fill_count_o   (fill_count_o)
  );

endmodule
